>>> rtl/core/mmcs_pkg.sv
// Package: shared constants, opcode and kind codes for the memory-to-memory step core.
`timescale 1ns / 1ps
package mmcs_pkg;
	localparam int MEM_WORDS_DEF = 4096;
	localparam int WORD_BITS_DEF = 16;
	localparam int ADDR_W = 12;
	localparam int DATA_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int FUNC_BITS = 8;
	localparam int DEVICE_FUNCS = 16;

	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_READ = 2'd1;
	localparam logic [1:0] KIND_EXEC = 2'd2;
	localparam logic [1:0] KIND_RESET = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_SP_ADDR = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IP_ADDR = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ERR_ADDR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SP_START = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PC_START = 3'd4;

	typedef enum logic [4:0] {
		OP_NOP = 5'd0, OP_PUSH = 5'd1, OP_POP = 5'd2, OP_NOT = 5'd3, OP_NEG = 5'd4,
		OP_DREF = 5'd5, OP_SET = 5'd6, OP_MOV = 5'd7, OP_DMOV = 5'd8, OP_AND = 5'd9,
		OP_OR = 5'd10, OP_XOR = 5'd11, OP_LSU = 5'd12, OP_RSU = 5'd13, OP_LSS = 5'd14,
		OP_RSS = 5'd15, OP_ADD = 5'd16, OP_SUB = 5'd17, OP_MUL = 5'd18, OP_DIV = 5'd19,
		OP_MOD = 5'd20, OP_INT = 5'd21, OP_JE = 5'd22, OP_JNE = 5'd23, OP_JL = 5'd24,
		OP_JLE = 5'd25, OP_JG = 5'd26, OP_JGE = 5'd27, OP_HALT = 5'd28
	} op_t;

	localparam logic [2:0] ERR_DIV0 = 3'b001;
	localparam logic [2:0] ERR_HW = 3'b010;
	localparam logic [2:0] ERR_UNK = 3'b100;
endpackage

>>> rtl/core/mmcs_ram.sv
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps
module mmcs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] addr,
	input logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

>>> rtl/core/memory_to_memory_cpu_step_core.sv
// Top level: memory-to-memory word machine, one item per start pulse.
`timescale 1ns / 1ps
// After reset the core clears its memory one word a cycle, with busy high.
// Each item then runs as a sequence of single-port memory accesses, each an issue state
// plus a wait state for the registered read, then a closing read of the error word and a
// finish step. DIV and MOD also pass through the bit-serial divider. The result shows on
// done for one cycle, in the first idle cycle after busy drops; the receiver cannot stall
// it and a new item may start in that cycle.
module memory_to_memory_cpu_step_core
	import mmcs_pkg::*;
#(
	parameter int MEM_WORDS = MEM_WORDS_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] kind,
	input logic [ADDR_W-1:0] addr,
	input logic [DATA_W-1:0] data,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_idx,
	input logic [DATA_W-1:0] cfg_data,
	output logic done,
	output logic [DATA_W-1:0] read_data,
	output logic running,
	output logic [2:0] error_flags
);
	localparam int AW = $clog2(MEM_WORDS);
	localparam int W = WORD_BITS;
	localparam int SW = $clog2(WORD_BITS) + 1;

	// micro-step states; each memory access has an issue state then a wait state
	typedef enum logic [20:0] {
		S_CLEAR = 21'd1 << 0, S_IDLE = 21'd1 << 1, S_ISSUE = 21'd1 << 2,
		S_WAIT = 21'd1 << 3, S_DIV = 21'd1 << 4, S_DONE = 21'd1 << 5
	} state_t;
	state_t state_q;

	// micro-op sequence labels
	typedef enum logic [5:0] {
		U_USR_W, U_USR_R, U_RST_E, U_RST_S, U_RST_I,
		U_F_IP, U_F_WORD, U_F_DEC, U_DISPATCH,
		U_SP_R, U_SP_W, U_X_R, U_X_W,
		U_Y_R, U_YY_R, U_DMOV_X, U_DMOV_W, U_SET_W,
		U_A_R, U_B_R, U_ALU_W,
		U_Z_R, U_JMP_W,
		U_ERR_R, U_ERR_W, U_UNF_R, U_UNF_W,
		U_FIN_R, U_FIN
	} uop_t;
	uop_t uop_q, ret_q;

	logic [ADDR_W-1:0] sp_addr_q, ip_addr_q, err_addr_q;
	logic [DATA_W-1:0] sp_start_q, pc_start_q;
	logic [1:0] kind_q;
	logic [ADDR_W-1:0] addr_q;
	logic [W-1:0] data_q;
	logic [W-1:0] op_q, x_q, y_q, z_q, a_q, b_q, t_q, ip_q;
	logic [1:0] nfetch_q;
	logic [2:0] errbit_q;
	logic run_q, unf_q;
	logic [AW:0] clr_q;

	// divider
	logic [W-1:0] quo_q, rem_q;
	logic [SW-1:0] dcnt_q;

	// memory port
	logic m_we;
	logic [AW-1:0] m_addr;
	logic [W-1:0] m_wdata, m_rdata;

	mmcs_ram #(.WIDTH(W), .DEPTH(MEM_WORDS)) u_ram (
		.clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wdata), .rdata(m_rdata)
	);

	function automatic logic [AW-1:0] wa(input logic [W-1:0] v);
		return v[AW-1:0];
	endfunction
	function automatic logic [AW-1:0] ca(input logic [ADDR_W-1:0] v);
		logic [ADDR_W+AW-1:0] e;
		e = {{AW{1'b0}}, v};
		return e[AW-1:0];
	endfunction

	// ALU, feeding the write data
	logic [W-1:0] alu;
	logic [2*W-1:0] prod;
	logic big;
	always_comb begin
		prod = a_q * b_q;
		big = (b_q >= W'(W));
		alu = a_q;
		case (op_q[4:0])
			OP_AND: alu = a_q & b_q;
			OP_OR: alu = a_q | b_q;
			OP_XOR: alu = a_q ^ b_q;
			OP_LSU, OP_LSS: alu = big ? '0 : a_q << b_q;
			OP_RSU: alu = big ? '0 : a_q >> b_q;
			OP_RSS: alu = big ? {W{a_q[W-1]}} : W'($signed(a_q) >>> b_q);
			OP_ADD: alu = a_q + b_q;
			OP_SUB: alu = a_q - b_q;
			OP_MUL: alu = prod[W-1:0];
			OP_DIV: alu = quo_q;
			OP_MOD: alu = rem_q;
			default: alu = a_q;
		endcase
	end

	logic cond;
	always_comb begin
		case (op_q[4:0])
			OP_JE: cond = (a_q == b_q);
			OP_JNE: cond = (a_q != b_q);
			OP_JL: cond = (a_q < b_q);
			OP_JLE: cond = (a_q <= b_q);
			OP_JG: cond = (a_q > b_q);
			default: cond = (a_q >= b_q);
		endcase
	end

	// divisor read back nonzero: enter the divider
	logic div_go;
	assign div_go = (uop_q == U_B_R) && (op_q[4:0] == OP_DIV || op_q[4:0] == OP_MOD) &&
		(m_rdata != '0);

	// memory request for the current micro-op
	always_comb begin
		m_we = 1'b0;
		m_addr = '0;
		m_wdata = '0;
		if (state_q == S_CLEAR) begin
			m_we = 1'b1;
			m_addr = clr_q[AW-1:0];
		end else if (state_q == S_ISSUE) begin
			case (uop_q)
				U_USR_W: begin m_we = 1'b1; m_addr = ca(addr_q); m_wdata = data_q; end
				U_USR_R: m_addr = ca(addr_q);
				U_RST_E: begin m_we = 1'b1; m_addr = ca(err_addr_q); end
				U_RST_S: begin
					m_we = 1'b1; m_addr = ca(sp_addr_q); m_wdata = W'(sp_start_q);
				end
				U_RST_I: begin
					m_we = 1'b1; m_addr = ca(ip_addr_q); m_wdata = W'(pc_start_q);
				end
				U_F_IP: m_addr = ca(ip_addr_q);
				U_F_WORD: m_addr = wa(ip_q);
				U_F_DEC: begin m_we = 1'b1; m_addr = ca(ip_addr_q); m_wdata = ip_q - 1'b1; end
				U_SP_R: m_addr = ca(sp_addr_q);
				U_SP_W: begin
					m_we = 1'b1; m_addr = ca(sp_addr_q);
					m_wdata = (op_q[4:0] == OP_PUSH) ? t_q + x_q : t_q - x_q;
				end
				U_X_R: m_addr = wa(x_q);
				U_X_W: begin
					m_we = 1'b1; m_addr = wa(x_q);
					m_wdata = (op_q[4:0] == OP_NOT) ? ~t_q : W'(0) - t_q;
				end
				U_Y_R: m_addr = wa(y_q);
				U_YY_R: m_addr = wa(t_q);
				U_DMOV_X: m_addr = wa(x_q);
				U_DMOV_W: begin m_we = 1'b1; m_addr = wa(a_q); m_wdata = b_q; end
				U_SET_W: begin m_we = 1'b1; m_addr = wa(x_q); m_wdata = t_q; end
				U_A_R: m_addr = wa(x_q);
				U_B_R: m_addr = wa(y_q);
				U_ALU_W: begin m_we = 1'b1; m_addr = wa(x_q); m_wdata = alu; end
				U_Z_R: m_addr = wa(z_q);
				U_JMP_W: begin m_we = 1'b1; m_addr = ca(ip_addr_q); m_wdata = t_q; end
				U_ERR_R: m_addr = ca(err_addr_q);
				U_ERR_W: begin
					m_we = 1'b1; m_addr = ca(err_addr_q); m_wdata = t_q | W'(errbit_q);
				end
				U_UNF_R: m_addr = ca(ip_addr_q);
				U_UNF_W: begin m_we = 1'b1; m_addr = ca(ip_addr_q); m_wdata = t_q + 1'b1; end
				U_FIN_R: m_addr = ca(err_addr_q);
				default: m_addr = '0;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			uop_q <= U_FIN;
			ret_q <= U_FIN;
			clr_q <= '0;
			sp_addr_q <= ADDR_W'(0);
			ip_addr_q <= ADDR_W'(1);
			err_addr_q <= ADDR_W'(2);
			sp_start_q <= DATA_W'(8);
			pc_start_q <= DATA_W'(4095);
			done <= 1'b0;
			read_data <= '0;
			running <= 1'b0;
			error_flags <= '0;
			nfetch_q <= '0;
			dcnt_q <= '0;
			kind_q <= '0;
			addr_q <= '0;
			data_q <= '0;
			op_q <= '0;
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
			a_q <= '0;
			b_q <= '0;
			t_q <= '0;
			ip_q <= '0;
			errbit_q <= '0;
			run_q <= 1'b0;
			unf_q <= 1'b0;
		end else begin
			done <= (state_q == S_ISSUE) && (uop_q == U_FIN);
			// configuration writes
			if (cfg_we) begin
				case (cfg_idx)
					CFG_SP_ADDR: sp_addr_q <= cfg_data[ADDR_W-1:0];
					CFG_IP_ADDR: ip_addr_q <= cfg_data[ADDR_W-1:0];
					CFG_ERR_ADDR: err_addr_q <= cfg_data[ADDR_W-1:0];
					CFG_SP_START: sp_start_q <= cfg_data;
					CFG_PC_START: pc_start_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW + 1)'(MEM_WORDS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						kind_q <= kind;
						addr_q <= addr;
						data_q <= W'(data);
						run_q <= 1'b0;
						unf_q <= 1'b0;
						state_q <= S_ISSUE;
						case (kind)
							KIND_WRITE: uop_q <= U_USR_W;
							KIND_READ: uop_q <= U_USR_R;
							KIND_EXEC: begin
								uop_q <= U_F_IP; nfetch_q <= 2'd0;
							end
							default: uop_q <= U_RST_E;
						endcase
					end
				end
				S_ISSUE: begin
					state_q <= (uop_q == U_FIN) ? S_IDLE :
						(uop_q == U_DISPATCH) ? S_ISSUE : S_WAIT;
					case (uop_q)
						U_DISPATCH: begin
							if (op_q == '0) begin
								run_q <= 1'b1; uop_q <= U_FIN_R;
							end else if (op_q >= W'(OP_HALT)) begin
								errbit_q <= ERR_UNK;
								uop_q <= (op_q != W'(OP_HALT)) ? U_ERR_R : U_UNF_R;
								unf_q <= 1'b1;
							end else if (nfetch_q == 2'd1) begin
								uop_q <= U_F_IP;
							end else if (op_q[4:0] == OP_PUSH || op_q[4:0] == OP_POP) begin
								uop_q <= U_SP_R;
							end else if (op_q[4:0] == OP_NOT || op_q[4:0] == OP_NEG) begin
								uop_q <= U_X_R;
							end else if (nfetch_q == 2'd2) begin
								uop_q <= U_F_IP;
							end else if (op_q[4:0] == OP_SET) begin
								t_q <= y_q; uop_q <= U_SET_W;
							end else if (op_q[4:0] == OP_MOV || op_q[4:0] == OP_DREF ||
									op_q[4:0] == OP_DMOV || op_q[4:0] == OP_INT) begin
								uop_q <= U_Y_R;
							end else if (op_q <= W'(OP_MOD)) begin
								uop_q <= U_A_R;
							end else if (nfetch_q == 2'd3) begin
								uop_q <= U_F_IP;
							end else begin
								uop_q <= U_A_R;
							end
						end
						default: ;
					endcase
				end
				S_DIV: begin
					// restoring divider, one quotient bit per cycle
					if (dcnt_q == '0) begin
						state_q <= S_ISSUE;
						uop_q <= U_ALU_W;
					end else begin
						dcnt_q <= dcnt_q - 1'b1;
					end
				end
				S_WAIT: begin
					state_q <= div_go ? S_DIV : S_ISSUE;
					case (uop_q)
						U_USR_W, U_RST_I, U_ALU_W, U_SET_W, U_X_W, U_SP_W, U_DMOV_W,
						U_JMP_W: uop_q <= U_FIN_R;
						U_USR_R: begin t_q <= m_rdata; uop_q <= U_FIN_R; end
						U_RST_E: uop_q <= U_RST_S;
						U_RST_S: uop_q <= U_RST_I;
						U_F_IP: begin ip_q <= m_rdata; uop_q <= U_F_WORD; end
						U_F_WORD: begin
							case (nfetch_q)
								2'd0: op_q <= m_rdata;
								2'd1: x_q <= m_rdata;
								2'd2: y_q <= m_rdata;
								default: z_q <= m_rdata;
							endcase
							uop_q <= U_F_DEC;
						end
						U_F_DEC: begin nfetch_q <= nfetch_q + 1'b1; uop_q <= U_DISPATCH; end
						U_SP_R: begin t_q <= m_rdata; uop_q <= U_SP_W; end
						U_X_R: begin t_q <= m_rdata; uop_q <= U_X_W; end
						U_Y_R: begin
							case (op_q[4:0])
								OP_DREF: begin t_q <= m_rdata; uop_q <= U_YY_R; end
								OP_MOV: begin t_q <= m_rdata; uop_q <= U_SET_W; end
								OP_DMOV: begin b_q <= m_rdata; uop_q <= U_DMOV_X; end
								default: begin
									if (m_rdata[FUNC_BITS-1:0] >= FUNC_BITS'(DEVICE_FUNCS)) begin
										errbit_q <= ERR_HW; uop_q <= U_ERR_R;
									end else begin
										t_q <= '0; uop_q <= U_SET_W;
									end
								end
							endcase
						end
						U_YY_R: begin t_q <= m_rdata; uop_q <= U_SET_W; end
						U_DMOV_X: begin a_q <= m_rdata; uop_q <= U_DMOV_W; end
						U_A_R: begin a_q <= m_rdata; uop_q <= U_B_R; end
						U_B_R: begin
							b_q <= m_rdata;
							if (op_q >= W'(OP_JE)) begin
								uop_q <= U_Z_R;
							end else if (op_q[4:0] == OP_DIV || op_q[4:0] == OP_MOD) begin
								if (m_rdata == '0) begin
									errbit_q <= ERR_DIV0; uop_q <= U_ERR_R;
								end else begin
									dcnt_q <= SW'(W);
								end
							end else begin
								uop_q <= U_ALU_W;
							end
						end
						U_Z_R: begin
							t_q <= m_rdata;
							run_q <= 1'b1;
							uop_q <= cond ? U_JMP_W : U_FIN_R;
						end
						U_ERR_R: begin t_q <= m_rdata; uop_q <= U_ERR_W; end
						U_ERR_W: uop_q <= unf_q ? U_UNF_R : U_FIN_R;
						U_UNF_R: begin t_q <= m_rdata; uop_q <= U_UNF_W; end
						U_UNF_W: uop_q <= U_FIN_R;
						U_FIN_R: begin
							error_flags <= m_rdata[2:0];
							running <= run_q;
							read_data <= (kind_q == KIND_READ) ? DATA_W'(t_q) : '0;
							uop_q <= U_FIN;
						end
						default: uop_q <= U_FIN_R;
					endcase
					// ops that write a result mark a normal finish, INT excepted
					if (uop_q == U_ALU_W || uop_q == U_SET_W || uop_q == U_X_W ||
							uop_q == U_SP_W || uop_q == U_DMOV_W) begin
						run_q <= !(op_q[4:0] == OP_INT);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// divider datapath: load on the divisor read, then shift the dividend into the remainder
	logic [W:0] trial;
	always_comb trial = {rem_q, quo_q[W-1]} - {1'b0, b_q};
	always_ff @(posedge clk) begin
		if (state_q == S_WAIT && uop_q == U_B_R) begin
			quo_q <= a_q;
			rem_q <= '0;
		end else if (state_q == S_DIV && dcnt_q != '0) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	// checks
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> state_q == S_IDLE) else $error("done outside idle");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && state_q != S_IDLE) |=> !done || $past(uop_q == U_FIN))
		else $error("done without finish step");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> b_q != '0) else $error("divide by zero entered divider");
endmodule

>>> verif/tb_top.sv
// Testbench for the memory-to-memory step core: directed programs, random programs, checks.
`timescale 1ns / 1ps
module tb_top
	import mmcs_pkg::*;
();

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	typedef struct packed {
		logic [1:0] kind;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
	} cmd_t;

	typedef struct packed {
		logic [DATA_W-1:0] rdata;
		logic run;
		logic [2:0] flags;
	} outcome_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] kind;
	logic [ADDR_W-1:0] addr;
	logic [DATA_W-1:0] data;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [DATA_W-1:0] cfg_data;
	logic done;
	logic [DATA_W-1:0] read_data;
	logic running;
	logic [2:0] error_flags;

	memory_to_memory_cpu_step_core dut (.*);

	// predictor state; pointer locations kept zero-extended to a word
	logic [15:0] mem_img [0:4095];
	logic [15:0] sp_loc, ip_loc, err_loc;
	logic [15:0] sp_init, pc_init;

	cmd_t pending_cmds[$];
	outcome_t expected_outcomes[$];
	int fail_count = 0;
	int cycle_count = 0;
	int send_idle_pct;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function automatic logic [15:0] mrd(logic [15:0] a);
		return mem_img[a[11:0]];
	endfunction

	task automatic mwr(logic [15:0] a, logic [15:0] v);
		mem_img[a[11:0]] = v;
	endtask

	task automatic fetch_word(output logic [15:0] v);
		logic [15:0] p;
		p = mrd(ip_loc);
		v = mrd(p);
		mwr(ip_loc, p - 16'd1);
	endtask

	task automatic raise_err(logic [2:0] b);
		mwr(err_loc, mrd(err_loc) | {13'd0, b});
	endtask

	// one instruction; returns running
	task automatic exec_instr(output logic run);
		logic [15:0] op, x, y, z, a, b;
		logic t;
		fetch_word(op);
		run = 1'b1;
		if (op == OP_NOP) return;
		if (op >= OP_HALT) begin
			if (op != OP_HALT) raise_err(ERR_UNK);
			mwr(ip_loc, mrd(ip_loc) + 16'd1);
			run = 1'b0;
			return;
		end
		fetch_word(x);
		case (op)
			OP_PUSH: begin mwr(sp_loc, mrd(sp_loc) + x); return; end
			OP_POP: begin mwr(sp_loc, mrd(sp_loc) - x); return; end
			OP_NOT: begin mwr(x, ~mrd(x)); return; end
			OP_NEG: begin mwr(x, -mrd(x)); return; end
			default: ;
		endcase
		fetch_word(y);
		if (op <= OP_INT) begin
			case (op)
				OP_DREF: begin mwr(x, mrd(mrd(y))); return; end
				OP_SET: begin mwr(x, y); return; end
				OP_MOV: begin mwr(x, mrd(y)); return; end
				OP_DMOV: begin mwr(mrd(x), mrd(y)); return; end
				OP_INT: begin
					b = mrd(y);
					if (b[7:0] >= DEVICE_FUNCS) raise_err(ERR_HW);
					else mwr(x, 16'd0);
					run = 1'b0;
					return;
				end
				default: ;
			endcase
			a = mrd(x);
			b = mrd(y);
			case (op)
				OP_AND: a = a & b;
				OP_OR: a = a | b;
				OP_XOR: a = a ^ b;
				OP_LSU, OP_LSS: a = (b >= 16) ? 16'd0 : a << b;
				OP_RSU: a = (b >= 16) ? 16'd0 : a >> b;
				OP_RSS: a = (b >= 16) ? {16{a[15]}} : 16'($signed(a) >>> b);
				OP_ADD: a = a + b;
				OP_SUB: a = a - b;
				OP_MUL: a = a * b;
				default: begin
					if (b == 0) begin
						raise_err(ERR_DIV0);
						run = 1'b0;
						return;
					end
					a = (op == OP_DIV) ? a / b : a % b;
				end
			endcase
			mwr(x, a);
			return;
		end
		fetch_word(z);
		a = mrd(x);
		b = mrd(y);
		case (op)
			OP_JE: t = a == b;
			OP_JNE: t = a != b;
			OP_JL: t = a < b;
			OP_JLE: t = a <= b;
			OP_JG: t = a > b;
			default: t = a >= b;
		endcase
		if (t) mwr(ip_loc, mrd(z));
	endtask

	task automatic predict_item(cmd_t c);
		outcome_t o;
		logic r;
		logic [15:0] ew;
		o = '0;
		case (c.kind)
			KIND_WRITE: mwr({4'd0, c.addr}, c.data);
			KIND_READ: o.rdata = mrd({4'd0, c.addr});
			KIND_EXEC: begin exec_instr(r); o.run = r; end
			default: begin
				mwr(err_loc, 16'd0);
				mwr(sp_loc, sp_init);
				mwr(ip_loc, pc_init);
			end
		endcase
		ew = mrd(err_loc);
		o.flags = ew[2:0];
		expected_outcomes.push_back(o);
	endtask

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			kind <= '0;
			addr <= '0;
			data <= '0;
		end else begin
			if (!start || !busy) begin
				if (pending_cmds.size() > 0 &&
						$urandom_range(99) >= send_idle_pct) begin
					cmd_t c;
					c = pending_cmds.pop_front();
					predict_item(c);
					start <= 1'b1;
					kind <= c.kind;
					addr <= c.addr;
					data <= c.data;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n && done) begin
			if (expected_outcomes.size() == 0) begin
				report_mismatch("unexpected item", read_data, 0);
			end else begin
				outcome_t e;
				e = expected_outcomes.pop_front();
				if (read_data !== e.rdata) report_mismatch("read_data", read_data, e.rdata);
				if (running !== e.run) report_mismatch("running", running, e.run);
				if (error_flags !== e.flags)
					report_mismatch("error_flags", error_flags, e.flags);
			end
		end
	end

	// timeout
	always @(posedge clk) begin
		if (cycle_count > 900000) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic [11:0] rand_addr();
		return 12'($urandom);
	endfunction

	task automatic push_cmd(logic [1:0] k, logic [11:0] a, logic [15:0] d);
		cmd_t c;
		c.kind = k;
		c.addr = a;
		c.data = d;
		pending_cmds.push_back(c);
	endtask

	task automatic wait_drain();
		while (pending_cmds.size() > 0 || expected_outcomes.size() > 0 || start)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	// register write while idle; predictor follows once it has landed
	task automatic write_reg(logic [CFG_IDX_W-1:0] i, logic [15:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= i;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (i)
			CFG_SP_ADDR: sp_loc = {4'd0, v[11:0]};
			CFG_IP_ADDR: ip_loc = {4'd0, v[11:0]};
			CFG_ERR_ADDR: err_loc = {4'd0, v[11:0]};
			CFG_SP_START: sp_init = v;
			CFG_PC_START: pc_init = v;
			default: ;
		endcase
	endtask

	// a program of n instructions at the ip, data in a small area
	task automatic push_program(int n);
		logic [11:0] pc, base;
		logic [15:0] op, w;
		int nops;
		pc = 12'($urandom_range(3000, 4095));
		base = 12'($urandom_range(16, 40));
		push_cmd(KIND_WRITE, ip_loc[11:0], {4'd0, pc});
		for (int i = 0; i < n; i++) begin
			op = ($urandom_range(19) == 0) ? 16'($urandom_range(29, 65535))
				: 16'($urandom_range(28));
			if ($urandom_range(3) != 0 && op == OP_HALT) op = 16'(OP_ADD);
			push_cmd(KIND_WRITE, pc, op);
			pc--;
			nops = (op == OP_NOP || op >= OP_HALT) ? 0 : (op <= OP_NEG) ? 1 :
				(op <= OP_INT) ? 2 : 3;
			for (int j = 0; j < nops; j++) begin
				w = ($urandom_range(9) == 0) ? 16'($urandom)
					: {4'd0, base + 12'($urandom_range(15))};
				push_cmd(KIND_WRITE, pc, w);
				pc--;
			end
		end
		for (int j = 0; j < 16; j++) begin
			case ($urandom_range(3))
				0: w = 16'($urandom_range(20));
				1: w = 16'd0;
				default: w = 16'($urandom);
			endcase
			push_cmd(KIND_WRITE, base + 12'(j), w);
		end
		for (int i = 0; i < n; i++) begin
			push_cmd(KIND_EXEC, 12'd0, 16'($urandom));
			if ($urandom_range(3) == 0) push_cmd(KIND_READ, base + 4'($urandom), 16'd0);
		end
	endtask

	initial begin
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		send_idle_pct = 28;
		mem_img = '{default: '0};
		sp_loc = 16'd0; ip_loc = 16'd1; err_loc = 16'd2; sp_init = 16'd8; pc_init = 16'd4095;
		arst_n = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;

		// directed: field extremes and special cases, then one-instruction random programs
		push_cmd(KIND_READ, 12'hFFF, 16'd0);
		push_cmd(KIND_WRITE, 12'hFFF, 16'hFFFF);
		push_cmd(KIND_READ, 12'hFFF, 16'hFFFF);
		push_cmd(KIND_RESET, 12'hFFF, 16'hFFFF);
		push_cmd(KIND_EXEC, 12'd0, 16'd0);
		push_cmd(KIND_WRITE, 12'd20, 16'h8001);
		push_cmd(KIND_WRITE, 12'd21, 16'd0);
		push_cmd(KIND_WRITE, 12'd4094, 16'(OP_DIV));
		push_cmd(KIND_WRITE, 12'd4093, 16'd20);
		push_cmd(KIND_WRITE, 12'd4092, 16'd21);
		push_cmd(KIND_EXEC, 12'd0, 16'd0);
		push_cmd(KIND_WRITE, 12'd4091, 16'(OP_RSS));
		push_cmd(KIND_WRITE, 12'd4090, 16'd20);
		push_cmd(KIND_WRITE, 12'd4089, 16'd20);
		push_cmd(KIND_EXEC, 12'd0, 16'd0);
		push_cmd(KIND_WRITE, 12'd4088, 16'd29);
		push_cmd(KIND_EXEC, 12'd0, 16'd0);
		push_cmd(KIND_WRITE, 12'd4088, 16'(OP_HALT));
		push_cmd(KIND_EXEC, 12'd0, 16'd0);
		push_cmd(KIND_READ, 12'd20, 16'd0);
		push_cmd(KIND_READ, 12'd1, 16'd0);
		wait_drain();
		for (int op = 0; op <= OP_HALT; op++) push_program(1);
		wait_drain();

		// random phases across register settings
		for (int ph = 0; ph < 9; ph++) begin
			if (ph == 3) send_idle_pct = 51;
			if (ph == 6) send_idle_pct = 0;
			case (ph % 3)
				0: begin
					write_reg(CFG_SP_ADDR, 16'($urandom_range(3, 9)));
					write_reg(CFG_IP_ADDR, 16'($urandom_range(10, 12)));
					write_reg(CFG_ERR_ADDR, 16'hFFFF);
				end
				1: begin
					write_reg(CFG_SP_ADDR, 16'h0FFF);
					write_reg(CFG_IP_ADDR, 16'd0);
					write_reg(CFG_ERR_ADDR, 16'd2);
				end
				default: begin
					write_reg(CFG_SP_ADDR, 16'($urandom_range(13, 15)));
					write_reg(CFG_IP_ADDR, 16'd13);
					write_reg(CFG_ERR_ADDR, 16'd13);
				end
			endcase
			write_reg(CFG_SP_START, (ph % 2) ? 16'hFFFF : 16'($urandom));
			write_reg(CFG_PC_START, (ph % 2) ? 16'd0 : 16'hFFFF);
			write_reg(CFG_UNUSED, 16'($urandom));
			push_cmd(KIND_RESET, 12'd0, 16'd0);
			for (int k = 0; k < 3; k++) begin
				push_program($urandom_range(2, 8));
				if ($urandom_range(2) == 0) begin
					push_cmd(KIND_WRITE, rand_addr(), 16'($urandom));
					push_cmd(KIND_READ, rand_addr(), 16'($urandom));
					push_cmd(KIND_EXEC, 12'd0, 16'd0);
					push_cmd(KIND_RESET, rand_addr(), 16'($urandom));
				end
			end
			wait_drain();
		end

		wait_drain();
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
